>>> design/nta_pkg.sv
// nta_pkg: shared types, constants and helper functions for the number to ascii formatter
// depends on nothing; imported by nta_dabble_stage, number_to_ascii_formatter and the testbench
`default_nettype none

package nta_pkg;

    localparam int DATA_W    = 32;             // width of the number to format
    localparam int DEC_DIGS  = 10;             // decimal digits of a 32-bit magnitude
    localparam int BCD_W     = 4 * DEC_DIGS;   // packed bcd width
    localparam int DD_BITS   = 8;              // binary bits consumed per dabble stage
    localparam int DD_STAGES = DATA_W / DD_BITS;

    // request format codes
    localparam logic [2:0] REQ_UDEC = 3'd0;
    localparam logic [2:0] REQ_SDEC = 3'd1;
    localparam logic [2:0] REQ_HEX2 = 3'd2;
    localparam logic [2:0] REQ_HEX4 = 3'd3;
    localparam logic [2:0] REQ_HEX8 = 3'd4;

    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_MINUS = 7'h2D;

    localparam logic [6:0] HEX_GLYPH [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    // item on its way through the conversion stages
    typedef struct packed {
        logic [DATA_W-1:0] mag;      // magnitude (decimal) or raw value (hex)
        logic [BCD_W-1:0]  bcd;      // partial bcd result
        logic              neg;      // minus sign to print
        logic              hex;      // hex format
        logic [3:0]        hex_top;  // index of the first hex nibble to print
    } t_item;

    // text ready for the character serializer
    typedef struct packed {
        logic [BCD_W-1:0] digits;    // ten nibble slots, slot 0 least significant
        logic [3:0]       idx;       // slot of the first character
        logic             sign;      // minus sign pending
        logic             hex;
    } t_text;

    // eight shift-add-3 steps of double dabble
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic [DD_BITS-1:0] bits);
        logic [BCD_W-1:0] b;
        b = bcd;
        for (int s = 0; s < DD_BITS; s++) begin
            for (int d = 0; d < DEC_DIGS; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[DD_BITS-1-s]};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

>>> design/number_to_ascii_formatter.sv
// number_to_ascii_formatter: top level, formats a 32-bit number as ascii decimal or hex text
// depends on nta_pkg and nta_dabble_stage
//
// usage
//   input channel: i_value, i_req_type with i_valid / o_stall; a request is taken at a
//   rising edge with i_valid high and o_stall low. format codes: 0 unsigned decimal,
//   1 signed decimal, 2 hex2, 3 hex4, 4 hex8; codes 5 to 7 are taken and dropped.
//   output channel: o_character, o_last_char with o_valid / i_stall; one character per
//   request on that side, most significant first, o_last_char marks the end of a number.
//   path: the input register loads at the edge that takes a number, then four double
//   dabble stages of eight bits each, digit search register, serializer register.
//   throughput: set by the character count, one to eleven characters per number, since the
//   serializer sends one character a cycle while i_stall is low; the stages before it take
//   a new number every cycle as long as they have room.
//   reset: synchronous, active low, empties all stages; nothing is sent afterwards.
//   stall: i_stall holds the current character; the stages behind it fill up and then
//   o_stall rises, no number is lost or repeated.
`default_nettype none

module number_to_ascii_formatter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_value,
    input  wire logic [2:0]  i_req_type,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_character,
    output logic             o_last_char
);
    import nta_pkg::*;

    // stage enables, back to front
    logic                 ser_take;
    logic                 en_fmt;
    logic [DD_STAGES-1:0] dd_en;
    logic                 en_in;

    // input stage
    logic  r_in_valid;
    t_item r_in;
    t_item n_in;
    logic  n_in_valid;

    // dabble stages
    logic  [DD_STAGES-1:0] dd_valid;
    t_item                 dd_item [DD_STAGES];

    // digit search stage
    logic  r_fmt_valid;
    t_text r_fmt;
    t_text n_fmt;
    logic [3:0] lead;

    // serializer
    logic  r_ser_valid;
    t_text r_ser;
    logic [3:0] cur_digit;

    // a new text loads once the current one has sent its last character
    assign ser_take = !r_ser_valid || (!i_stall && o_last_char);
    assign en_fmt   = !r_fmt_valid || ser_take;
    assign dd_en[DD_STAGES-1] = !dd_valid[DD_STAGES-1] || en_fmt;
    generate
        for (genvar k = 0; k < DD_STAGES - 1; k++) begin : g_en
            assign dd_en[k] = !dd_valid[k] || dd_en[k+1];
        end
    endgenerate
    assign en_in   = !r_in_valid || dd_en[0];
    assign o_stall = !en_in;

    // input decode: magnitude, sign, hex width
    always_comb begin
        n_in.mag     = i_value;
        n_in.bcd     = '0;
        n_in.neg     = 1'b0;
        n_in.hex     = 1'b0;
        n_in.hex_top = 4'd0;
        n_in_valid   = 1'b1;
        unique case (i_req_type)
            REQ_UDEC: ;
            REQ_SDEC: begin
                if (i_value[DATA_W-1]) begin
                    n_in.neg = 1'b1;
                    n_in.mag = '0 - i_value;
                end
            end
            REQ_HEX2: begin
                n_in.hex     = 1'b1;
                n_in.hex_top = 4'd1;
            end
            REQ_HEX4: begin
                n_in.hex     = 1'b1;
                n_in.hex_top = 4'd3;
            end
            REQ_HEX8: begin
                n_in.hex     = 1'b1;
                n_in.hex_top = 4'd7;
            end
            default: n_in_valid = 1'b0;   // unused code, dropped
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en_in) begin
            r_in_valid <= i_valid && n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in <= n_in;
        end
    end

    // double dabble, eight magnitude bits per stage, msb first
    generate
        for (genvar k = 0; k < DD_STAGES; k++) begin : g_dd
            if (k == 0) begin : g_first
                nta_dabble_stage u_stage (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (dd_en[k]),
                    .i_valid (r_in_valid),
                    .i_item  (r_in),
                    .i_bits  (r_in.mag[DATA_W-1 -: DD_BITS]),
                    .o_valid (dd_valid[k]),
                    .o_item  (dd_item[k])
                );
            end else begin : g_next
                nta_dabble_stage u_stage (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (dd_en[k]),
                    .i_valid (dd_valid[k-1]),
                    .i_item  (dd_item[k-1]),
                    .i_bits  (dd_item[k-1].mag[DATA_W-1-k*DD_BITS -: DD_BITS]),
                    .o_valid (dd_valid[k]),
                    .o_item  (dd_item[k])
                );
            end
        end
    endgenerate

    // leading digit search; zero keeps a single digit
    always_comb begin
        lead = 4'd0;
        for (int d = 1; d < DEC_DIGS; d++) begin
            if (dd_item[DD_STAGES-1].bcd[4*d +: 4] != 4'd0) begin
                lead = 4'(d);
            end
        end
        n_fmt.sign = dd_item[DD_STAGES-1].neg;
        n_fmt.hex  = dd_item[DD_STAGES-1].hex;
        if (dd_item[DD_STAGES-1].hex) begin
            n_fmt.digits = {{(BCD_W-DATA_W){1'b0}}, dd_item[DD_STAGES-1].mag};
            n_fmt.idx    = dd_item[DD_STAGES-1].hex_top;
        end else begin
            n_fmt.digits = dd_item[DD_STAGES-1].bcd;
            n_fmt.idx    = lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_valid <= 1'b0;
        end else if (en_fmt) begin
            r_fmt_valid <= dd_valid[DD_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_fmt) begin
            r_fmt <= n_fmt;
        end
    end

    // serializer: sign first, then digit slots from idx down to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
        end else if (ser_take) begin
            r_ser_valid <= r_fmt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_take) begin
            r_ser <= r_fmt;
        end else if (!i_stall) begin
            if (r_ser.sign) begin
                r_ser.sign <= 1'b0;
            end else begin
                r_ser.idx <= r_ser.idx - 4'd1;
            end
        end
    end

    assign cur_digit   = r_ser.digits[{r_ser.idx, 2'b00} +: 4];
    assign o_valid     = r_ser_valid;
    assign o_character = r_ser.sign ? ASCII_MINUS : HEX_GLYPH[cur_digit];
    assign o_last_char = !r_ser.sign && (r_ser.idx == 4'd0);

    // the last character never comes from a slot above zero or from the sign
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char |-> !r_ser.sign && r_ser.idx == 4'd0)
        else $error("last character flagged too early");

    // a number's text leaves without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char && !i_stall |=> o_valid)
        else $error("gap inside a number's text");

    // hex text never carries a sign
    a_hex_nosign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid && r_ser.hex |-> !r_ser.sign)
        else $error("minus sign on hex text");

    // decimal slots hold bcd digits only
    a_bcd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid && !r_ser.hex && !r_ser.sign |-> cur_digit < 4'd10)
        else $error("bad bcd digit from double dabble");

    // decimal text never starts beyond the tenth digit
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fmt_valid && !r_fmt.hex |-> r_fmt.idx < 4'd10)
        else $error("leading digit index out of range");

endmodule

`default_nettype wire

>>> design/nta_dabble_stage.sv
// nta_dabble_stage: one pipeline register stage of the binary to bcd conversion
// depends on nta_pkg (t_item, dd_step)
`default_nettype none

module nta_dabble_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire nta_pkg::t_item               i_item,
    input  wire logic [nta_pkg::DD_BITS-1:0]  i_bits,
    output logic                              o_valid,
    output nta_pkg::t_item                    o_item
);
    import nta_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item = i_item;
        if (!i_item.hex) begin
            n_item.bcd = dd_step(i_item.bcd, i_bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> tb/sv/nta_text_checker.sv
// nta_text_checker: watches both channels of number_to_ascii_formatter, predicts the text
// of every accepted request and compares it character by character
// depends on nta_pkg for the format codes and ascii constants
module nta_text_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic [31:0] i_value,
    input  wire logic [2:0]  i_req_type,
    input  wire logic        i_chr_valid,
    input  wire logic        i_chr_stall,
    input  wire logic [6:0]  i_character,
    input  wire logic        i_last_char,
    output int               o_pending = 0,
    output int               o_errors = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    import nta_pkg::*;

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam int         PRINT_CAP     = 40;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_glyph;

    t_glyph glyphs_due[$];
    t_glyph want;

    task automatic report_mismatch(input string what);
        o_errors++;
        if (o_errors <= PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    // text of one number, most significant character first
    function automatic void queue_text(input logic [31:0] value, input logic [2:0] fmt);
        logic [6:0]  text[$];
        logic [6:0]  dec_rev[10];
        logic [31:0] mag;
        logic [3:0]  nib;
        int          n;
        int          width;
        mag = value;
        n = 0;
        width = 0;
        case (fmt)
            REQ_UDEC, REQ_SDEC: begin
                if (fmt == REQ_SDEC && value[31]) begin
                    text.push_back(ASCII_MINUS);
                    mag = 32'd0 - value;
                end
                do begin
                    dec_rev[n] = ASCII_ZERO + 7'(mag % 32'd10);
                    mag = mag / 32'd10;
                    n++;
                end while (mag != 32'd0);
                for (int k = n - 1; k >= 0; k--) begin
                    text.push_back(dec_rev[k]);
                end
            end
            REQ_HEX2, REQ_HEX4, REQ_HEX8: begin
                width = (fmt == REQ_HEX2) ? 2 : (fmt == REQ_HEX4) ? 4 : 8;
                for (int k = width - 1; k >= 0; k--) begin
                    nib = value[4*k +: 4];
                    text.push_back(nib < 4'd10 ? ASCII_ZERO + 7'(nib)
                                               : ASCII_UPPER_A + 7'(nib) - 7'd10);
                end
            end
            default: begin
            end
        endcase
        foreach (text[k]) begin
            glyphs_due.push_back('{character: text[k], last: (k == text.size() - 1)});
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                queue_text(i_value, i_req_type);
            end
            if (i_chr_valid && !i_chr_stall) begin
                if (glyphs_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                              i_character, i_last_char));
                end else begin
                    want = glyphs_due.pop_front();
                    if (i_character !== want.character) begin
                        report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                                  i_character, want.character));
                    end
                    if (i_last_char !== want.last) begin
                        report_mismatch($sformatf("last_char %0b, want %0b on 0x%02h",
                                                  i_last_char, want.last, want.character));
                    end
                end
            end
        end
        o_pending <= glyphs_due.size();
    end

endmodule

>>> tb/sv/tb.sv
// tb: stimulus and verdict for number_to_ascii_formatter
// depends on nta_pkg, the formatter rtl and nta_text_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nta_pkg::*;

    // codes past hex8 are taken by the block and dropped
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 360;
    localparam int IDLE_PCT     = 36;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;     // extra wait after the drain, to catch stray characters

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [31:0] i_value    = '0;
    logic [2:0]  i_req_type = REQ_UDEC;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [6:0]  o_character;
    logic        o_last_char;

    int pending;
    int errors;
    int gap_pct   = IDLE_PCT;
    int stall_pct = IDLE_PCT;
    int cycles    = 0;

    number_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_req_type  (i_req_type),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    nta_text_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_stall (o_stall),
        .i_value     (i_value),
        .i_req_type  (i_req_type),
        .i_chr_valid (o_valid),
        .i_chr_stall (i_stall),
        .i_character (o_character),
        .i_last_char (o_last_char),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one request, with random idle cycles in front of it;
    // returns in the time step of the edge that took it, so the next
    // call can keep i_valid high without a low pulse
    task automatic send_request(input logic [31:0] value, input logic [2:0] fmt);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_value    <= value;
        i_req_type <= fmt;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // hold off until every expected character has come out
    task automatic wait_for_empty();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    // numbers spread over all digit counts, with powers of ten and their
    // neighbors, small negatives and plain random words
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(5))
            0: v = 32'($urandom_range(0, 99));
            1: v = $urandom() >> $urandom_range(0, 31);
            2: v = 32'd0 - 32'($urandom_range(1, 1000));
            3: begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                v = p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial begin
        int          taken;
        logic [2:0]  fmt;

        taken = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, single digits, decade edges, full range
        send_request(32'd0,          REQ_UDEC);
        send_request(32'd9,          REQ_UDEC);
        send_request(32'd10,         REQ_UDEC);
        send_request(32'd1000000000, REQ_UDEC);
        send_request(32'hFFFF_FFFF,  REQ_UDEC);
        send_request(32'h8000_0000,  REQ_UDEC);
        // signed: zero, largest positive, most negative, minus one, minus ten, a small positive
        send_request(32'd0,          REQ_SDEC);
        send_request(32'h7FFF_FFFF,  REQ_SDEC);
        send_request(32'h8000_0000,  REQ_SDEC);
        send_request(32'hFFFF_FFFF,  REQ_SDEC);
        send_request(32'hFFFF_FFF6,  REQ_SDEC);
        send_request(32'd7,          REQ_SDEC);
        // hex widths; upper nibbles must be cut off for the short ones
        send_request(32'h0000_0000,  REQ_HEX2);
        send_request(32'h1234_56AF,  REQ_HEX2);
        send_request(32'hFFFF_FFFF,  REQ_HEX4);
        send_request(32'hDEAD_BEEF,  REQ_HEX4);
        send_request(32'h0000_0000,  REQ_HEX8);
        send_request(32'h89AB_CDEF,  REQ_HEX8);
        send_request(32'hFFFF_FFFF,  REQ_HEX8);
        // unused codes, nothing may come out for these; then a plain decimal
        send_request(32'h1234_5678,  REQ_SPARE_LO);
        send_request(32'hFFFF_FFFF,  REQ_SPARE_LO + 3'd1);
        send_request(32'h0000_0000,  REQ_SPARE_HI);
        send_request(32'd42,         REQ_UDEC);
        wait_for_empty();

        // random part; a stretch in the middle runs with no idling on either side
        while (taken < RANDOM_ITEMS) begin
            if (taken >= 150 && taken < 250) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = IDLE_PCT;
                stall_pct = IDLE_PCT;
            end
            if (taken == 300) begin
                wait_for_empty();
            end
            if ($urandom_range(99) < 6) begin
                fmt = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            end else begin
                fmt = 3'($urandom_range(REQ_UDEC, REQ_HEX8));
                taken++;
            end
            send_request(pick_value(), fmt);
        end

        // drain, then a few more cycles to catch anything extra
        wait_for_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
